// ===== hdl/mas_pkg.sv =====
// Shared types and codes for the middle access stack.
// Used by the controller, the datapath and the top level; no dependencies.
package mas_pkg;

    // request codes as they arrive on the input channel
    typedef enum logic [1:0] {
        REQ_PUSH     = 2'd0,
        REQ_POP      = 2'd1,
        REQ_READ_MID = 2'd2,
        REQ_DEL_MID  = 2'd3
    } t_req;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic    push_wr;       // write pushed word at top, count up
        logic    rd_top;        // read the top entry
        logic    rd_mid;        // read the middle entry, load shift index
        logic    rd_next;       // read the entry above the shift index
        logic    wr_shift;      // write read word at shift index, advance
        logic    cnt_dec;       // count down
        logic    out_load;      // load the result register
        logic    out_use_rdata; // result word from read data, else zero
        t_status out_status;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic mid_top;     // middle is the top entry, nothing to shift
        logic shift_last;  // current shift write is the last one
    } t_dp_stat;

endpackage

// ===== hdl/mas_ctrl.sv =====
// Controller for the middle access stack: handshakes and request sequencing.
// Depends on mas_pkg; drives the datapath through t_dp_cmd.
module mas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    output logic              o_valid,
    input  logic              i_ready,
    input  mas_pkg::t_dp_stat i_stat,
    output mas_pkg::t_dp_cmd  o_cmd
);
    import mas_pkg::*;

    t_state   r_state, n_state;
    t_req     r_req, n_req;
    logic     r_out_valid, n_out_valid;
    logic     w_out_free;

    // state and handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= REQ_PUSH;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = w_out_free;
                if (i_valid && w_out_free) begin
                    n_req = t_req'(i_req_type);
                    case (t_req'(i_req_type))
                        REQ_PUSH: begin
                            o_cmd.out_load = 1'b1;
                            n_out_valid    = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.push_wr    = 1'b1;
                                o_cmd.out_status = ST_OK;
                            end
                        end
                        REQ_POP, REQ_READ_MID, REQ_DEL_MID: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                                n_out_valid      = 1'b1;
                            end else if (t_req'(i_req_type) == REQ_POP) begin
                                o_cmd.rd_top = 1'b1;
                                n_state      = S_READ;
                            end else if (t_req'(i_req_type) == REQ_READ_MID) begin
                                o_cmd.rd_mid = 1'b1;
                                n_state      = S_READ;
                            end else begin
                                o_cmd.rd_mid = 1'b1;
                                if (i_stat.mid_top) begin
                                    // middle is on top: drop it directly
                                    o_cmd.cnt_dec    = 1'b1;
                                    o_cmd.out_load   = 1'b1;
                                    o_cmd.out_status = ST_OK;
                                    n_out_valid      = 1'b1;
                                end else begin
                                    n_state = S_SHIFT_RD;
                                end
                            end
                        end
                        default: begin
                            o_cmd = '0;
                        end
                    endcase
                end
            end
            S_READ: begin
                // read data is ready: hand it out
                o_cmd.out_load      = 1'b1;
                o_cmd.out_use_rdata = 1'b1;
                o_cmd.out_status    = ST_OK;
                o_cmd.cnt_dec       = (r_req == REQ_POP);
                n_out_valid         = 1'b1;
                n_state             = S_IDLE;
            end
            S_SHIFT_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // move one entry down; finish after the top one
                o_cmd.wr_shift = 1'b1;
                if (i_stat.shift_last) begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mas_datapath.sv =====
// Datapath for the middle access stack: entry memory, count, shift index,
// result register. Depends on mas_pkg; commanded by mas_ctrl.
module mas_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mas_pkg::t_dp_cmd   i_cmd,
    input  logic signed [31:0] i_push_value,
    output mas_pkg::t_dp_stat  o_stat,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status,
    output logic [6:0]         o_occupancy
);
    import mas_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         w_raddr, w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata, w_in_word;
    logic                  w_wr_en;
    logic [CW-1:0]         w_count_m1, w_mid, w_idx_ext;
    logic [DATA_WIDTH+31:0] w_in_ext;
    logic [DATA_WIDTH+31:0] w_out_ext;
    logic [CW+6:0]         w_occ_ext;
    logic signed [31:0]    r_result_value;
    logic [1:0]            r_status;
    logic [6:0]            r_occupancy;

    // count, middle and shift index arithmetic
    assign w_count_m1 = r_count - CW'(1);
    assign w_mid      = r_count >> 1;
    assign w_idx_ext  = CW'(r_idx);

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count >= CW'(DEPTH));
    assign o_stat.mid_top    = (r_count <= CW'(2));
    assign o_stat.shift_last = ((w_idx_ext + CW'(2)) >= r_count);

    // fit the pushed word to the stored width
    assign w_in_ext  = {{DATA_WIDTH{1'b0}}, i_push_value};
    assign w_in_word = w_in_ext[DATA_WIDTH-1:0];

    // memory address and data selection
    always_comb begin
        if (i_cmd.rd_top) begin
            w_raddr = w_count_m1[AW-1:0];
        end else if (i_cmd.rd_mid) begin
            w_raddr = w_mid[AW-1:0];
        end else begin
            w_raddr = r_idx + AW'(1);
        end
    end

    assign w_wr_en = i_cmd.push_wr || i_cmd.wr_shift;
    assign w_waddr = i_cmd.push_wr ? r_count[AW-1:0] : r_idx;
    assign w_wdata = i_cmd.push_wr ? w_in_word : r_rdata;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // element count
    always_comb begin
        n_count = r_count;
        if (i_cmd.push_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = w_count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // shift index: start at the middle, advance per moved entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_mid) begin
            r_idx <= w_mid[AW-1:0];
        end else if (i_cmd.wr_shift) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // result register
    assign w_out_ext = {{32{r_rdata[DATA_WIDTH-1]}}, r_rdata};
    assign w_occ_ext = {7'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result_value <= i_cmd.out_use_rdata ? signed'(w_out_ext[31:0]) : 32'sd0;
            r_status       <= i_cmd.out_status;
            r_occupancy    <= w_occ_ext[6:0];
        end
    end

    assign o_result_value = r_result_value;
    assign o_status       = r_status;
    assign o_occupancy    = r_occupancy;

endmodule

// ===== hdl/middle_access_stack_unit.sv =====
// Middle access stack top level: push, pop, read middle, delete middle.
// Push and error results load the result register directly; pop and read middle
// read the entry memory first. Delete middle drops the middle at once for up to
// two entries, else moves each entry above it down via S_SHIFT_RD and S_SHIFT_WR.
// A new item is taken only once the last is done, in the cycle its predecessor's
// result leaves or while no result is pending. Reset clears count and handshake state only.
module middle_access_stack_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_push_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status,
    output logic [6:0]         o_occupancy
);
    import mas_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing and handshakes
    mas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage and result register
    mas_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_push_value   (i_push_value),
        .o_stat         (w_stat),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

endmodule
